@@ src/bfiq_pkg.sv @@
// Package for the bloom filter block: store geometry, divider step sizes,
// FSM state type and the structs between the top level and the modulo unit.
// No dependencies.
package bfiq_pkg;

  localparam int STORE_BITS    = 65536;
  localparam int WORD_BITS     = 64;
  localparam int WORD_SHIFT    = 6;
  localparam int STORE_WORDS   = (STORE_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W        = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int POS_W         = $clog2(STORE_BITS);

  localparam int HASH_W        = 64;
  localparam int SIZE_W        = 17;
  localparam int SIZE_RESET    = 65536;

  localparam int STEP_BITS     = 4;
  localparam int MOD_STEPS     = HASH_W / STEP_BITS;
  localparam int CNT_W         = $clog2(MOD_STEPS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_UPDATE
  } bfiq_state_t;

  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } bfiq_mod_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] rem;
  } bfiq_mod_rsp_t;

  // Clamp the programmed size: zero acts as one, above the store acts as the store.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] fb);
    logic [SIZE_W-1:0] n;
    n = fb;
    if (fb == '0) begin
      n = SIZE_W'(1);
    end else if (32'(fb) > 32'(STORE_BITS)) begin
      n = SIZE_W'(STORE_BITS);
    end
    return n;
  endfunction

  // One restoring step: shift in one dividend bit, subtract when it fits.
  function automatic logic [SIZE_W-1:0] mod_step(input logic [SIZE_W-1:0] rem,
                                                 input logic              din,
                                                 input logic [SIZE_W-1:0] div);
    logic [SIZE_W:0] t;
    t = {rem, din};
    if (t >= {1'b0, div}) begin
      t = t - {1'b0, div};
    end
    return t[SIZE_W-1:0];
  endfunction

endpackage

@@ src/bloom_filter_insert_query.sv @@
// Bloom filter top level: sequencer, bit-store RAM and modulo unit.
// Depends on bfiq_pkg, bfiq_ram and bfiq_mod.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one hash of a key's group
//   with its operation (0 query, 1 insert) and a last-of-group mark. The
//   block transfers one item, reduces the hash modulo the effective filter
//   size, reads the store word, tests the bit and, for an insert, writes
//   the word back with the bit set.
//   Output channel (out_valid / out_stall) carries maybe_present, one
//   transfer per group, on the item marked last.
//   One item is in work at a time: the input is open only in the idle
//   state. The iterative modulo unit reduces four dividend bits per cycle;
//   after its done flag the block reads the store word, runs its update
//   step and returns to idle to accept the next item.
//   Reset: a clearing pass zeroes every store word, one word per cycle,
//   with in_stall high; cfg writes are taken throughout.
//   Stall: a pending result holds in the output register; the block keeps
//   working and only waits in its update step when a further result is due.
module bloom_filter_insert_query (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [bfiq_pkg::SIZE_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  logic [bfiq_pkg::HASH_W-1:0] in_hash_value,
  input  logic                        in_last_hash,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_maybe_present
);

  bfiq_pkg::bfiq_state_t            state_r, state_nxt;
  logic [bfiq_pkg::SIZE_W-1:0]      filter_bits_r, filter_bits_nxt;
  logic [bfiq_pkg::ADDR_W-1:0]      clr_addr_r, clr_addr_nxt;
  logic                             all_hit_r, all_hit_nxt;
  logic                             op_r, op_nxt;
  logic                             last_r, last_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_maybe_r, out_maybe_nxt;

  bfiq_pkg::bfiq_mod_req_t          mod_req;
  bfiq_pkg::bfiq_mod_rsp_t          mod_rsp;

  logic                             in_xfer;
  logic                             upd_go;
  logic                             clr_last;
  logic [bfiq_pkg::POS_W-1:0]       pos;
  logic [bfiq_pkg::ADDR_W-1:0]      word_addr;
  logic [bfiq_pkg::WORD_BITS-1:0]   bit_mask;
  logic                             hit;

  logic                             ram_wr_en;
  logic [bfiq_pkg::ADDR_W-1:0]      ram_wr_addr;
  logic [bfiq_pkg::WORD_BITS-1:0]   ram_wr_data;
  logic                             ram_rd_en;
  logic [bfiq_pkg::WORD_BITS-1:0]   ram_rd_data;

  // Bit position from the remainder; it is always below the store size.
  assign pos       = bfiq_pkg::POS_W'(mod_rsp.rem);
  assign word_addr = bfiq_pkg::ADDR_W'(pos >> bfiq_pkg::WORD_SHIFT);
  assign bit_mask  = bfiq_pkg::WORD_BITS'(1) << pos[bfiq_pkg::WORD_SHIFT-1:0];
  assign hit       = (ram_rd_data & bit_mask) != '0;

  assign in_xfer  = in_valid && !in_stall;
  assign clr_last = clr_addr_r == bfiq_pkg::ADDR_W'(bfiq_pkg::STORE_WORDS - 1);
  // Hold the update while a new result would overwrite one still waiting.
  assign upd_go   = (state_r == bfiq_pkg::ST_UPDATE) &&
                    (!last_r || !out_valid_r || !out_stall);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfiq_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = bfiq_pkg::ST_IDLE;
        end
      end
      bfiq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = bfiq_pkg::ST_DIV;
        end
      end
      bfiq_pkg::ST_DIV: begin
        if (mod_rsp.done) begin
          state_nxt = bfiq_pkg::ST_READ;
        end
      end
      bfiq_pkg::ST_READ: begin
        state_nxt = bfiq_pkg::ST_UPDATE;
      end
      bfiq_pkg::ST_UPDATE: begin
        if (upd_go) begin
          state_nxt = bfiq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bfiq_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall    = 1'b1;
    ram_wr_en   = 1'b0;
    ram_wr_addr = word_addr;
    ram_wr_data = ram_rd_data | bit_mask;
    ram_rd_en   = 1'b0;
    case (state_r)
      bfiq_pkg::ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr_r;
        ram_wr_data = '0;
      end
      bfiq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      bfiq_pkg::ST_READ: begin
        ram_rd_en = 1'b1;
      end
      bfiq_pkg::ST_UPDATE: begin
        ram_wr_en = upd_go && op_r;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign mod_req.start    = in_xfer;
  assign mod_req.dividend = in_hash_value;
  assign mod_req.divisor  = bfiq_pkg::eff_size(filter_bits_r);

  // Register next values
  always_comb begin
    filter_bits_nxt = cfg_wr_en ? cfg_wr_data : filter_bits_r;
    clr_addr_nxt    = (state_r == bfiq_pkg::ST_CLEAR) ? clr_addr_r + 1'b1 : clr_addr_r;
    op_nxt          = in_xfer ? in_operation : op_r;
    last_nxt        = in_xfer ? in_last_hash : last_r;
    all_hit_nxt     = all_hit_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_maybe_nxt   = out_maybe_r;
    if (upd_go) begin
      if (last_r) begin
        // Report the group and rearm the running flag.
        all_hit_nxt   = 1'b1;
        out_valid_nxt = 1'b1;
        out_maybe_nxt = all_hit_r && hit;
      end else begin
        all_hit_nxt = all_hit_r && hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bfiq_pkg::ST_CLEAR;
      filter_bits_r <= bfiq_pkg::SIZE_W'(bfiq_pkg::SIZE_RESET);
      clr_addr_r    <= '0;
      all_hit_r     <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      filter_bits_r <= filter_bits_nxt;
      clr_addr_r    <= clr_addr_nxt;
      all_hit_r     <= all_hit_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    last_r      <= last_nxt;
    out_maybe_r <= out_maybe_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_maybe_present = out_maybe_r;

  bfiq_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  bfiq_ram #(
    .WIDTH (bfiq_pkg::WORD_BITS),
    .DEPTH (bfiq_pkg::STORE_WORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (word_addr),
    .rd_data (ram_rd_data)
  );

endmodule

@@ src/bfiq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module bfiq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/bfiq_mod.sv @@
// Iterative modulo unit: reduces a 64-bit hash by the filter size,
// STEP_BITS restoring steps per cycle. Depends on bfiq_pkg.
module bfiq_mod (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bfiq_pkg::bfiq_mod_req_t req,
  output bfiq_pkg::bfiq_mod_rsp_t rsp
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [bfiq_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [bfiq_pkg::HASH_W-1:0]    hash_r, hash_nxt;
  logic [bfiq_pkg::SIZE_W-1:0]    div_r, div_nxt;
  logic [bfiq_pkg::SIZE_W-1:0]    rem_r, rem_nxt;
  logic [bfiq_pkg::SIZE_W-1:0]    rem_step;

  // Consume the top bits of the hash, most significant first.
  always_comb begin
    rem_step = rem_r;
    for (int i = 0; i < bfiq_pkg::STEP_BITS; i++) begin
      rem_step = bfiq_pkg::mod_step(rem_step, hash_r[bfiq_pkg::HASH_W-1-i], div_r);
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    hash_nxt = hash_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      hash_nxt = req.dividend;
      div_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = rem_step;
      hash_nxt = hash_r << bfiq_pkg::STEP_BITS;
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == bfiq_pkg::CNT_W'(bfiq_pkg::MOD_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    hash_r <= hash_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

@@ src/bfiq_checker.sv @@
// Port-level checker for the bloom filter block, bound to the top level.
// Depends on bfiq_pkg.
module bfiq_port_checks (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        cfg_wr_en,
  input logic [bfiq_pkg::SIZE_W-1:0] cfg_wr_data,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        in_operation,
  input logic [bfiq_pkg::HASH_W-1:0] in_hash_value,
  input logic                        in_last_hash,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_maybe_present
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_maybe_present))
    else $error("stalled result changed or dropped");

  // The clearing pass follows reset, so no item is taken straight away.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open right after reset");

  // One item in work at a time.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  // A result cannot appear the cycle after a transfer: the reduction takes longer.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind bloom_filter_insert_query bfiq_port_checks u_bfiq_port_checks (
  .clk               (clk),
  .rst_n             (rst_n),
  .cfg_wr_en         (cfg_wr_en),
  .cfg_wr_data       (cfg_wr_data),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_operation      (in_operation),
  .in_hash_value     (in_hash_value),
  .in_last_hash      (in_last_hash),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_maybe_present (out_maybe_present)
);
